@@ hw/rtl/nfa_string_acceptor_top_assert.svh @@
// ----------------------------------------------------------------------------
// nfa_string_acceptor_top_assert
// Assertion macros for nfa_string_acceptor_top.
// Each macro expands to one labeled concurrent assertion on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef NFA_STRING_ACCEPTOR_TOP_ASSERT_SVH
`define NFA_STRING_ACCEPTOR_TOP_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define NFA_SA_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("nfa_string_acceptor: assertion failed");

// pre holds -> post holds in the next cycle
`define NFA_SA_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("nfa_string_acceptor: assertion failed");

`endif

@@ hw/rtl/nfa_sa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_sa_pkg
// Shared widths, request and register codes, and chain control types.
// ----------------------------------------------------------------------------
package nfa_sa_pkg;

  localparam int REQ_W       = 2;
  localparam int STATE_IDX_W = 4;
  localparam int SYM_W       = 3;
  localparam int MASK_W      = 16;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [REQ_W-1:0] REQ_TRANS = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EPS   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SYM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DFA_MODE    = 1'b1;

  // token moving down the cell chain
  typedef struct packed {
    logic vld;
    logic adv;   // 1: advance through transition rows, 0: epsilon pass
  } chain_ctl_t;

  // per-cell table write strobes
  typedef struct packed {
    logic trans;
    logic eps;
  } cell_wr_t;

endpackage

@@ hw/rtl/nfa_sa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_sa_in_if
// Request channel: table row writes and stream symbols.
// ----------------------------------------------------------------------------
interface nfa_sa_in_if;
  logic                                valid;
  logic                                ready;
  logic [nfa_sa_pkg::REQ_W-1:0]        req_type;
  logic [nfa_sa_pkg::STATE_IDX_W-1:0]  state_index;
  logic [nfa_sa_pkg::SYM_W-1:0]        symbol;
  logic [nfa_sa_pkg::MASK_W-1:0]       next_mask;
  logic                                end_of_string;

  modport source (
    output valid, req_type, state_index, symbol, next_mask, end_of_string,
    input  ready
  );
  modport sink (
    input  valid, req_type, state_index, symbol, next_mask, end_of_string,
    output ready
  );
endinterface

@@ hw/rtl/nfa_sa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_sa_out_if
// Result channel: accept flag and closed final state set per string.
// ----------------------------------------------------------------------------
interface nfa_sa_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [nfa_sa_pkg::MASK_W-1:0]  final_states;

  modport source (
    output valid, accepted, final_states,
    input  ready
  );
  modport sink (
    input  valid, accepted, final_states,
    output ready
  );
endinterface

@@ hw/rtl/nfa_sa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_sa_cell
// One automaton state: its epsilon row and transition rows, and one stage of
// the chain that ORs its row into the passing accumulator.
// ----------------------------------------------------------------------------
module nfa_sa_cell #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 8,
  parameter int IDX         = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           dfa_mode,
  input  nfa_sa_pkg::cell_wr_t           wr,
  input  logic [$clog2(NUM_SYMBOLS)-1:0] wr_addr,
  input  logic [NUM_STATES-1:0]          wr_data,
  input  logic [$clog2(NUM_SYMBOLS)-1:0] rd_addr,
  input  nfa_sa_pkg::chain_ctl_t         in_ctl,
  input  logic [NUM_STATES-1:0]          in_acc,
  input  logic [NUM_STATES-1:0]          in_set,
  output nfa_sa_pkg::chain_ctl_t         out_ctl,
  output logic [NUM_STATES-1:0]          out_acc,
  output logic [NUM_STATES-1:0]          out_set
);

  logic [NUM_STATES-1:0] trans_mem [NUM_SYMBOLS];
  logic [NUM_STATES-1:0] trow;
  logic [NUM_STATES-1:0] eps;
  logic [NUM_STATES-1:0] contrib;

  always_ff @(posedge clk) begin
    if (wr.trans) begin
      trans_mem[wr_addr] <= wr_data;
    end
    trow <= trans_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= '0;
    end else if (wr.eps) begin
      eps <= wr_data;
    end
  end

  always_comb begin
    if (in_ctl.adv) begin
      contrib = in_set[IDX] ? trow : '0;
    end else begin
      contrib = (in_acc[IDX] && !dfa_mode) ? eps : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_acc <= in_acc | contrib;
    out_set <= in_set;
  end

endmodule

@@ hw/rtl/nfa_string_acceptor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_string_acceptor_top
// Finite automaton simulator with epsilon closure over a chain of state cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes words of three kinds: a transition row write, an
//   epsilon row write, or a stream symbol. A symbol sends a token down the
//   chain of N = NUM_STATES cells. The epsilon closure repeats passes until
//   nothing changes (1 to N passes, one pass in dfa mode), then one advance
//   pass. A symbol marked end_of_string runs a second closure and loads the
//   result word: accepted and final_states.
//   res holds one result word in a register; a new request is taken while it
//   waits. A later result stalls the block until res drains.
//   cfg port: cfg_we/cfg_idx/cfg_wdata, write only, while idle.
//   Reset clears the control registers and the epsilon rows and sets the
//   active set to state 0, then sweeps the transition rows to zero with
//   req.ready low.
// ----------------------------------------------------------------------------
module nfa_string_acceptor_top #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nfa_sa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [nfa_sa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  nfa_sa_in_if.sink                           req,
  nfa_sa_out_if.source                        res
);

  localparam int SW = $clog2(NUM_SYMBOLS);
  localparam int N  = NUM_STATES;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_ADV  = 2'd1;
  localparam logic [1:0] PH_POST = 2'd2;

  logic [1:0]                        state;
  logic [1:0]                        ph;
  logic [SW-1:0]                     clr_addr;
  logic [N-1:0]                      active;
  logic [N-1:0]                      cur_q;
  logic [SW-1:0]                     sym_q;
  logic                              sym_ok_q;
  logic                              eos_q;
  logic [nfa_sa_pkg::MASK_W-1:0]     accept_mask;
  logic                              dfa_mode;

  nfa_sa_pkg::chain_ctl_t            inj_ctl;
  nfa_sa_pkg::chain_ctl_t            inj_ctl_next;
  logic [N-1:0]                      inj_acc;
  logic [N-1:0]                      inj_set;

  logic                              res_vld;
  logic                              res_accepted;
  logic [nfa_sa_pkg::MASK_W-1:0]     res_fin;

  nfa_sa_pkg::chain_ctl_t            ctl_c [N+1];
  logic [N-1:0]                      acc_c [N+1];
  logic [N-1:0]                      set_c [N+1];
  logic [N:0]                        vld_vec;
  nfa_sa_pkg::cell_wr_t              cell_wr [N];

  logic                              acc_w;
  logic                              sym_take;
  logic                              pass_done;
  logic                              settled;
  logic                              res_load;
  logic                              clearing;
  logic                              sym_ok;
  logic [SW-1:0]                     wr_addr;
  logic [N-1:0]                      wr_data;
  logic                              out_free;
  logic [N-1:0]                      adv_res;
  logic [N-1:0]                      fin_sel;
  logic [nfa_sa_pkg::MASK_W-1:0]     fin_low;

  assign req.ready    = (state == ST_IDLE);
  assign acc_w        = req.valid && req.ready;
  assign sym_take     = acc_w && req.req_type == nfa_sa_pkg::REQ_SYM;
  assign pass_done    = (state == ST_RUN) && ctl_c[N].vld;
  assign settled      = (acc_c[N] == cur_q);
  assign clearing     = (state == ST_CLR);
  assign sym_ok       = 32'(req.symbol) < NUM_SYMBOLS;
  assign wr_addr      = clearing ? clr_addr : SW'(req.symbol);
  assign wr_data      = clearing ? '0 : N'(req.next_mask);
  assign out_free     = !res_vld || res.ready;
  assign res_load     = out_free && ((state == ST_HOLD) ||
                                     (pass_done && ph == PH_POST && settled));
  assign adv_res      = sym_ok_q ? acc_c[N] : '0;
  assign fin_sel      = (state == ST_HOLD) ? cur_q : acc_c[N];
  assign fin_low      = nfa_sa_pkg::MASK_W'(fin_sel);

  assign res.valid        = res_vld;
  assign res.accepted     = res_accepted;
  assign res.final_states = res_fin;

  assign ctl_c[0] = inj_ctl;
  assign acc_c[0] = inj_acc;
  assign set_c[0] = inj_set;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_wr[i].trans = clearing ||
      (acc_w && req.req_type == nfa_sa_pkg::REQ_TRANS && sym_ok &&
       32'(req.state_index) == i);
    assign cell_wr[i].eps =
      acc_w && req.req_type == nfa_sa_pkg::REQ_EPS && 32'(req.state_index) == i;

    nfa_sa_cell #(
      .NUM_STATES  (N),
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .dfa_mode (dfa_mode),
      .wr       (cell_wr[i]),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (sym_q),
      .in_ctl   (ctl_c[i]),
      .in_acc   (acc_c[i]),
      .in_set   (set_c[i]),
      .out_ctl  (ctl_c[i+1]),
      .out_acc  (acc_c[i+1]),
      .out_set  (set_c[i+1])
    );
  end

  for (genvar k = 0; k <= N; k++) begin : g_vld
    assign vld_vec[k] = ctl_c[k].vld;
  end

  // token injected at the head of the chain
  always_comb begin
    inj_ctl_next = '0;
    if (sym_take) begin
      inj_ctl_next = '{vld: 1'b1, adv: 1'b0};
    end else if (pass_done) begin
      case (ph)
        PH_PRE, PH_POST: begin
          if (!settled) begin
            inj_ctl_next = '{vld: 1'b1, adv: 1'b0};
          end else if (ph == PH_PRE) begin
            inj_ctl_next = '{vld: 1'b1, adv: 1'b1};
          end
        end
        PH_ADV: begin
          if (eos_q) begin
            inj_ctl_next = '{vld: 1'b1, adv: 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      ph          <= PH_PRE;
      clr_addr    <= '0;
      active      <= N'(1);
      accept_mask <= '0;
      dfa_mode    <= 1'b0;
      inj_ctl     <= '0;
      res_vld     <= 1'b0;
    end else begin
      inj_ctl <= inj_ctl_next;
      res_vld <= res_load || (res_vld && !res.ready);

      if (cfg_we) begin
        case (cfg_idx)
          nfa_sa_pkg::REG_ACCEPT_MASK: accept_mask <= cfg_wdata;
          nfa_sa_pkg::REG_DFA_MODE:    dfa_mode    <= cfg_wdata[0];
          default: ;
        endcase
      end

      case (state)
        ST_CLR: begin
          clr_addr <= SW'(clr_addr + 1'b1);
          if (clr_addr == SW'(NUM_SYMBOLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (sym_take) begin
            sym_q    <= SW'(req.symbol);
            sym_ok_q <= sym_ok;
            eos_q    <= req.end_of_string;
            cur_q    <= active;
            inj_acc  <= active;
            ph       <= PH_PRE;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (ctl_c[N].vld) begin
            case (ph)
              PH_PRE, PH_POST: begin
                if (!settled) begin
                  cur_q   <= acc_c[N];
                  inj_acc <= acc_c[N];
                end else if (ph == PH_PRE) begin
                  inj_acc <= '0;
                  inj_set <= acc_c[N];
                  ph      <= PH_ADV;
                end else if (out_free) begin
                  res_accepted <= |(fin_low & accept_mask);
                  res_fin      <= fin_low;
                  active       <= N'(1);
                  state        <= ST_IDLE;
                end else begin
                  state <= ST_HOLD;
                end
              end
              PH_ADV: begin
                if (eos_q) begin
                  cur_q   <= adv_res;
                  inj_acc <= adv_res;
                  ph      <= PH_POST;
                end else begin
                  active <= adv_res;
                  state  <= ST_IDLE;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            res_accepted <= |(fin_low & accept_mask);
            res_fin      <= fin_low;
            active       <= N'(1);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "nfa_string_acceptor_top_assert.svh"

  `NFA_SA_ASSERT_IMP(a_one_token, 1'b1, $countones(vld_vec) <= 1)
  `NFA_SA_ASSERT_IMP(a_idle_no_token, state == ST_IDLE, vld_vec == '0)
  `NFA_SA_ASSERT_NXT(a_sym_starts, sym_take, state == ST_RUN && inj_ctl.vld)
  `NFA_SA_ASSERT_IMP(a_hold_full, state == ST_HOLD, res_vld)

endmodule
